// ===== design/ipba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ipba_pkg;

  // Field widths of the ports
  localparam int ACTION_W = 2;
  localparam int ID_W     = 8;
  localparam int POOL_W   = 9;

  localparam logic [POOL_W-1:0] POOL_RESET = 9'd256;

  // Bitmap row geometry: one row holds WORD_W used bits
  localparam int WORD_W  = 32;
  localparam int WORD_SH = 5;

  // Action codes; code 3 has no meaning and yields an empty result
  typedef enum logic [ACTION_W-1:0] {
    ACT_GET     = 2'd0,
    ACT_CHECK   = 2'd1,
    ACT_RELEASE = 2'd2
  } ipba_action_t;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } ipba_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // take the input beat and read its first row
    logic rd_next;  // read the next bitmap row
    logic commit;   // write back the row and load the output register
  } ipba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_get;
    logic found;
    logic last_row;
    logic out_full;
  } ipba_sts_t;

endpackage

`default_nettype wire

// ===== design/ipba_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ipba_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output ipba_pkg::ipba_cmd_t     cmd,
  input  wire ipba_pkg::ipba_sts_t sts
);
  import ipba_pkg::*;

  ipba_state_t state;
  ipba_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // a get walks the rows until a free bit or the pool end
        if (sts.is_get && !sts.found && !sts.last_row) begin
          cmd.rd_next = 1'b1;
        end else if (!sts.out_full) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ipba_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ipba_dp #(
  parameter int MAX_IDS = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ipba_pkg::POOL_W-1:0]   cfg_data,
  input  wire logic [ipba_pkg::ACTION_W-1:0] action,
  input  wire logic [ipba_pkg::ID_W-1:0]     id_in,
  input  wire ipba_pkg::ipba_cmd_t           cmd,
  output ipba_pkg::ipba_sts_t                sts,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic [ipba_pkg::ID_W-1:0]          id_out,
  output logic                               id_valid,
  output logic                               available
);
  import ipba_pkg::*;

  localparam int ROWS = (MAX_IDS + WORD_W - 1) / WORD_W;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW   = ($clog2(MAX_IDS + 1) > POOL_W) ? $clog2(MAX_IDS + 1) : POOL_W;
  localparam int XW   = CW + 1;
  localparam logic [XW-1:0] MAX_X  = XW'(MAX_IDS);
  localparam logic [XW-1:0] WORD_X = XW'(WORD_W);

  // Bitmap rows; a row never written reads as all free
  logic [WORD_W-1:0] mem [ROWS];
  logic [ROWS-1:0]   row_vld;

  logic [POOL_W-1:0]   pool_size;
  logic [ACTION_W-1:0] act_r;
  logic [ID_W-1:0]     id_r;
  logic [AW-1:0]       row;
  logic [WORD_W-1:0]   rd_word;
  logic                rd_vld;

  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] word;
  logic [XW-1:0]     pool_x;
  logic [XW-1:0]     limit_x;
  logic [XW-1:0]     base_x;
  logic [XW-1:0]     rem_x;
  logic [XW-1:0]     get_id;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] free;
  logic [WORD_W-1:0] lsb;
  logic [WORD_SH-1:0] idx;
  logic [WORD_W-1:0] bit_sel;
  logic              found;
  logic              in_range;
  logic              wr_en;
  logic [WORD_W-1:0] wr_word;
  logic [ID_W-1:0]   id_out_next;
  logic              id_valid_next;
  logic              available_next;

  // Pool size register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= POOL_RESET;
    end else if (cfg_we) begin
      pool_size <= cfg_data;
    end
  end

  // Row to read: on load, row 0 for get and the row of the identifier otherwise; else the next row
  always_comb begin
    if (cmd.load) begin
      if (action == ACT_GET) begin
        rd_addr = '0;
      end else begin
        rd_addr = AW'(XW'(id_in) >> WORD_SH);
      end
    end else begin
      rd_addr = row + AW'(1);
    end
  end

  // Item registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action;
      id_r  <= id_in;
    end
    if (cmd.load || cmd.rd_next) begin
      row <= rd_addr;
    end
  end

  // Bitmap read port, registered
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.rd_next) begin
      rd_word <= mem[rd_addr];
      rd_vld  <= row_vld[rd_addr];
    end
  end

  // Bitmap write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[row] <= wr_word;
    end
  end

  // Row valid flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (wr_en) begin
      row_vld[row] <= 1'b1;
    end
  end

  // Pool limit and the in-pool mask of the current row
  always_comb begin
    word    = rd_vld ? rd_word : '0;
    pool_x  = XW'(pool_size);
    limit_x = (pool_x > MAX_X) ? MAX_X : pool_x;
    base_x  = XW'({row, {WORD_SH{1'b0}}});
    rem_x   = limit_x - base_x;
    if (limit_x <= base_x) begin
      mask = '0;
    end else if (rem_x >= WORD_X) begin
      mask = '1;
    end else begin
      mask = (WORD_W'(1) << rem_x[WORD_SH-1:0]) - WORD_W'(1);
    end
  end

  // Lowest free bit of the row
  always_comb begin
    free  = ~word & mask;
    lsb   = free & (~free + WORD_W'(1));
    found = |free;
    idx   = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (lsb[i]) begin
        idx = idx | WORD_SH'(i);
      end
    end
    get_id = base_x | XW'(idx);
  end

  // Identifier bit for check and release
  assign in_range = XW'(id_r) < limit_x;
  assign bit_sel  = WORD_W'(1) << id_r[WORD_SH-1:0];

  // Row write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_word = word & ~bit_sel;
    case (act_r)
      ACT_GET: begin
        wr_en   = cmd.commit && found;
        wr_word = word | lsb;
      end
      ACT_RELEASE: begin
        wr_en = cmd.commit && in_range;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Result fields
  always_comb begin
    id_out_next    = '0;
    id_valid_next  = 1'b0;
    available_next = 1'b0;
    case (act_r)
      ACT_GET: begin
        id_out_next   = found ? get_id[ID_W-1:0] : '0;
        id_valid_next = found;
      end
      ACT_CHECK: begin
        available_next = in_range && !(|(word & bit_sel));
      end
      default: begin
        id_out_next = '0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      id_out    <= id_out_next;
      id_valid  <= id_valid_next;
      available <= available_next;
    end
  end

  // Status
  always_comb begin
    sts.is_get   = act_r == ACT_GET;
    sts.found    = found;
    sts.last_row = !(limit_x > base_x + WORD_X);
    sts.out_full = out_valid && out_stall;
  end

endmodule

`default_nettype wire

// ===== design/id_pool_bitmap_allocator.sv =====
// Sequence: check, release and unused codes read the row of the identifier when the input
//   beat is taken and load the output register on commit; a get scans r rows, r = 1..ceil(MAX_IDS/32).
// Throughput: one item at a time, the next input beat is taken only after the result is loaded;
//   a get scans one row of 32 used bits per cycle, set by the single read port of the row memory;
//   output stall holds the item in evaluation.
// Reset (rst, synchronous): pool_size 256, all identifiers free at once via per-row
//   valid flags, output empty; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module id_pool_bitmap_allocator #(
  parameter int MAX_IDS = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ipba_pkg::POOL_W-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ipba_pkg::ACTION_W-1:0] action,
  input  wire logic [ipba_pkg::ID_W-1:0]     id_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ipba_pkg::ID_W-1:0]          id_out,
  output logic                               id_valid,
  output logic                               available
);
  import ipba_pkg::*;

  ipba_cmd_t cmd;
  ipba_sts_t sts;

  // Register writes always taken
  assign cfg_ready = 1'b1;

  ipba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  ipba_dp #(
    .MAX_IDS (MAX_IDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .action    (action),
    .id_in     (id_in),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .id_out    (id_out),
    .id_valid  (id_valid),
    .available (available)
  );

endmodule

`default_nettype wire

// ===== design/ipba_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ipba_chk (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          cfg_valid,
  input wire logic                          cfg_ready,
  input wire logic [ipba_pkg::POOL_W-1:0]   cfg_data,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic [ipba_pkg::ACTION_W-1:0] action,
  input wire logic [ipba_pkg::ID_W-1:0]     id_in,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [ipba_pkg::ID_W-1:0]     id_out,
  input wire logic                          id_valid,
  input wire logic                          available
);

  // Stalled result beat stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // Stalled result beat keeps its fields
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(id_out) && $stable(id_valid) && $stable(available))
    else $error("result fields changed while stalled");

  // One item at a time: a taken input beat closes the input side
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  // A get that finds nothing and every non-get report id_out zero
  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !id_valid |-> id_out == '0)
    else $error("id_out nonzero without a handed-out identifier");

  // A result is either a handed-out identifier or a check answer, never both
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(id_valid && available))
    else $error("id_valid and available both set");

endmodule

bind id_pool_bitmap_allocator ipba_chk u_ipba_chk (.*);

`default_nettype wire
